// ----- rtl/core/rgbbs_pkg.sv -----
// Shared constants, codes and types of the RGB bilinear sampler.
package rgbbs_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAC_BITS  = 8;

    localparam int COORD_W   = 24;
    localparam int RGB_W     = 24;
    localparam int CH_W      = 8;
    localparam int DIM_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 24;
    localparam int OP_W      = 2;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam int SUM_W = COORD_W + 1;
    localparam int INT_W = SUM_W - FRAC_BITS + 1;
    localparam int FW_W  = FRAC_BITS + 1;
    localparam int W_W   = 2 * FRAC_BITS + 1;
    localparam int ACC_W = 2 * FRAC_BITS + CH_W + 1;

    localparam logic [OP_W-1:0] OP_WRITE    = 2'd0;
    localparam logic [OP_W-1:0] OP_NEAREST  = 2'd1;
    localparam logic [OP_W-1:0] OP_BILINEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 2'd3;

    localparam logic [DIM_W-1:0] RST_IMAGE_DIM = 9'd256;

    typedef struct packed {
        logic       load;
        logic       ctr;
        logic       wr;
        logic       rd;
        logic       near;
        logic [1:0] sel;
        logic       acc;
    } t_cmd;

endpackage

// ----- rtl/core/rgbbs_ctrl.sv -----
// Controller state machine of the RGB bilinear sampler.
module rgbbs_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [rgbbs_pkg::OP_W-1:0]    i_opcode,
    output logic                          busy,
    output logic                          o_valid,
    output rgbbs_pkg::t_cmd               o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WRITE,
        S_ISSUE,
        S_FIN
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    logic       r_near, n_near;
    logic       r_acc;
    logic       r_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_near  = r_near;
        o_cmd   = '0;
        o_cmd.acc  = r_acc;
        o_cmd.sel  = r_cnt;
        o_cmd.near = r_near;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    o_cmd.ctr  = (i_opcode != rgbbs_pkg::OP_WRITE);
                    n_cnt      = '0;
                    case (i_opcode)
                        rgbbs_pkg::OP_WRITE: begin
                            n_state = S_WRITE;
                        end
                        rgbbs_pkg::OP_NEAREST: begin
                            n_state = S_ISSUE;
                            n_near  = 1'b1;
                        end
                        rgbbs_pkg::OP_BILINEAR: begin
                            n_state = S_ISSUE;
                            n_near  = 1'b0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WRITE: begin
                o_cmd.wr = 1'b1;
                n_state  = S_IDLE;
            end
            S_ISSUE: begin
                o_cmd.rd = 1'b1;
                if (r_near || r_cnt == 2'd3) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_near  <= 1'b0;
            r_acc   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_near  <= n_near;
            r_acc   <= o_cmd.rd;
            r_valid <= (r_state == S_FIN);
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_IDLE))
        else $error("result strobe outside idle");

    a_valid_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> ($past(r_state) == S_FIN))
        else $error("result strobe without finishing step");

    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> (r_state == S_IDLE))
        else $error("write step overran");

    a_four_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE && !r_near && r_cnt != 2'd3) |=> (r_state == S_ISSUE))
        else $error("bilinear read sequence cut short");

    a_acc_follows_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc |-> ($past(r_state) == S_ISSUE))
        else $error("accumulate without a read");

endmodule

// ----- rtl/core/rgbbs_dp.sv -----
// Datapath of the RGB bilinear sampler: config registers, pixel store, weights, sums.
module rgbbs_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rgbbs_pkg::t_cmd                   i_cmd,
    input  logic                              i_cfg_we,
    input  logic [rgbbs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rgbbs_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic [rgbbs_pkg::COORD_W-1:0]     i_x_coord,
    input  logic [rgbbs_pkg::COORD_W-1:0]     i_y_coord,
    input  logic [rgbbs_pkg::RGB_W-1:0]       i_pixel_rgb,
    output logic [rgbbs_pkg::RGB_W-1:0]       o_sample_rgb
);

    localparam int SUM_W  = rgbbs_pkg::SUM_W;
    localparam int INT_W  = rgbbs_pkg::INT_W;
    localparam int FB     = rgbbs_pkg::FRAC_BITS;
    localparam int FW_W   = rgbbs_pkg::FW_W;
    localparam int W_W    = rgbbs_pkg::W_W;
    localparam int ACC_W  = rgbbs_pkg::ACC_W;
    localparam int CH_W   = rgbbs_pkg::CH_W;
    localparam int ADDR_W = rgbbs_pkg::ADDR_W;
    localparam int MAG_W  = INT_W - 1;
    localparam logic [FW_W-1:0] F_ONE  = FW_W'(1) << FB;
    localparam logic [W_W-1:0]  W_FULL = W_W'(1) << (2 * FB);

    logic [rgbbs_pkg::DIM_W-1:0]   r_img_w, r_img_h;
    logic [rgbbs_pkg::COORD_W-1:0] r_ctr_x, r_ctr_y;
    logic [SUM_W-1:0]              r_sx, r_sy;
    logic [rgbbs_pkg::RGB_W-1:0]   r_pix;
    logic [rgbbs_pkg::RGB_W-1:0]   mem [rgbbs_pkg::DEPTH];
    logic [rgbbs_pkg::RGB_W-1:0]   r_rdata;
    logic [W_W-1:0]                r_w;
    logic                          r_in;
    logic [ACC_W-1:0]              r_acc [3];

    logic [SUM_W-1:0]  n_sx, n_sy;
    logic [FB-1:0]     fx, fy;
    logic [INT_W-1:0]  x_fl, y_fl, col, row;
    logic              x_inc, y_inc;
    logic [MAG_W-1:0]  eff_w, eff_h;
    logic              in_img;
    logic [ADDR_W-1:0] addr;
    logic [FW_W-1:0]   wx, wy;
    logic [W_W-1:0]    n_w;

    assign n_sx = {i_x_coord[rgbbs_pkg::COORD_W-1], i_x_coord}
                + (i_cmd.ctr ? {r_ctr_x[rgbbs_pkg::COORD_W-1], r_ctr_x} : '0);
    assign n_sy = {i_y_coord[rgbbs_pkg::COORD_W-1], i_y_coord}
                + (i_cmd.ctr ? {r_ctr_y[rgbbs_pkg::COORD_W-1], r_ctr_y} : '0);

    assign fx   = r_sx[FB-1:0];
    assign fy   = r_sy[FB-1:0];
    assign x_fl = {r_sx[SUM_W-1], r_sx[SUM_W-1:FB]};
    assign y_fl = {r_sy[SUM_W-1], r_sy[SUM_W-1:FB]};

    always_comb begin
        if (i_cmd.rd && i_cmd.near) begin
            x_inc = r_sx[SUM_W-1] && (fx != '0);
            y_inc = r_sy[SUM_W-1] && (fy != '0);
        end else if (i_cmd.rd) begin
            x_inc = i_cmd.sel[1];
            y_inc = i_cmd.sel[0];
        end else begin
            x_inc = 1'b0;
            y_inc = 1'b0;
        end
    end

    assign col = x_fl + INT_W'(x_inc);
    assign row = y_fl + INT_W'(y_inc);

    assign eff_w = (MAG_W'(r_img_w) > MAG_W'(rgbbs_pkg::MAX_WIDTH))
                 ? MAG_W'(rgbbs_pkg::MAX_WIDTH) : MAG_W'(r_img_w);
    assign eff_h = (MAG_W'(r_img_h) > MAG_W'(rgbbs_pkg::MAX_HEIGHT))
                 ? MAG_W'(rgbbs_pkg::MAX_HEIGHT) : MAG_W'(r_img_h);

    assign in_img = !col[INT_W-1] && !row[INT_W-1]
                 && (col[MAG_W-1:0] < eff_w) && (row[MAG_W-1:0] < eff_h);

    assign addr = ADDR_W'(ADDR_W'(row[rgbbs_pkg::ROW_W-1:0])
                * ADDR_W'(rgbbs_pkg::MAX_WIDTH))
                + ADDR_W'(col[rgbbs_pkg::COL_W-1:0]);

    assign wx  = i_cmd.sel[1] ? FW_W'(fx) : F_ONE - FW_W'(fx);
    assign wy  = i_cmd.sel[0] ? FW_W'(fy) : F_ONE - FW_W'(fy);
    assign n_w = i_cmd.near ? W_FULL : W_W'(wx * wy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= rgbbs_pkg::RST_IMAGE_DIM;
            r_img_h <= rgbbs_pkg::RST_IMAGE_DIM;
            r_ctr_x <= '0;
            r_ctr_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rgbbs_pkg::REG_IMAGE_WIDTH:  r_img_w <= i_cfg_data[rgbbs_pkg::DIM_W-1:0];
                rgbbs_pkg::REG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[rgbbs_pkg::DIM_W-1:0];
                rgbbs_pkg::REG_CENTER_X:     r_ctr_x <= i_cfg_data;
                rgbbs_pkg::REG_CENTER_Y:     r_ctr_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_pix <= i_pixel_rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && in_img) begin
            mem[addr] <= r_pix;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_w  <= n_w;
            r_in <= in_img;
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
        logic [ACC_W-1:0] prod;
        logic [CH_W-1:0]  chan;
        assign chan = r_rdata[c*CH_W +: CH_W];
        assign prod = r_in ? ACC_W'(chan * r_w) : '0;

        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                r_acc[c] <= '0;
            end else if (i_cmd.acc) begin
                r_acc[c] <= r_acc[c] + prod;
            end
        end

        assign o_sample_rgb[c*CH_W +: CH_W] =
            (r_acc[c][ACC_W-1:2*FB+CH_W] != '0) ? {CH_W{1'b1}}
                                                 : r_acc[c][2*FB +: CH_W];
    end

endmodule

// ----- rtl/core/rgb_image_bilinear_sampler.sv -----
// Top level of the RGB image bilinear sampler.
//
//  channel   ports                                          handshake
//  ------    ---------------------------------------------  --------------------------
//  command   i_opcode i_x_coord i_y_coord i_pixel_rgb       start high, busy low
//  result    o_sample_rgb                                   o_valid, one cycle
//  config    i_cfg_idx i_cfg_data                           i_cfg_we, no wait
//
//  A write word passes a write step; a sample word passes its read steps, then a finishing step.
//  A bilinear sample makes four reads of the single-port pixel store, one per cycle.
//  For a sample, o_valid rises in the same cycle that busy falls; the next word may be taken in that cycle.
//  Reset restores the control state and config registers; the pixel store and datapath registers keep no reset state.
//  The receiver cannot stall; each result stands for exactly one cycle.
module rgb_image_bilinear_sampler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [rgbbs_pkg::OP_W-1:0]        i_opcode,
    input  logic [rgbbs_pkg::COORD_W-1:0]     i_x_coord,
    input  logic [rgbbs_pkg::COORD_W-1:0]     i_y_coord,
    input  logic [rgbbs_pkg::RGB_W-1:0]       i_pixel_rgb,
    output logic                              o_valid,
    output logic [rgbbs_pkg::RGB_W-1:0]       o_sample_rgb,
    input  logic                              i_cfg_we,
    input  logic [rgbbs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rgbbs_pkg::CFG_W-1:0]       i_cfg_data
);

    rgbbs_pkg::t_cmd cmd;

    rgbbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_cmd    (cmd)
    );

    rgbbs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .i_pixel_rgb  (i_pixel_rgb),
        .o_sample_rgb (o_sample_rgb)
    );

endmodule

// ----- verif/tb_rgb_image_bilinear_sampler.sv -----
// Self-checking testbench of the RGB image bilinear sampler: directed and random write, sample and reserved words.
`timescale 1ns / 100ps

module tb_rgb_image_bilinear_sampler;
    import rgbbs_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam longint COORD_MIN   = -64'sd8388608;
    localparam longint COORD_MAX   = 64'sd8388607;
    localparam int     SETTLE      = 12;
    localparam int     CYCLE_LIMIT = 500000;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [RGB_W-1:0]   rgb;
        bit                 drain;
    } t_sampler_word;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 start        = 1'b0;
    logic                 busy;
    logic [OP_W-1:0]      i_opcode     = '0;
    logic [COORD_W-1:0]   i_x_coord    = '0;
    logic [COORD_W-1:0]   i_y_coord    = '0;
    logic [RGB_W-1:0]     i_pixel_rgb  = '0;
    logic                 o_valid;
    logic [RGB_W-1:0]     o_sample_rgb;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx    = '0;
    logic [CFG_W-1:0]     i_cfg_data   = '0;

    rgb_image_bilinear_sampler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_x_coord   (i_x_coord),
        .i_y_coord   (i_y_coord),
        .i_pixel_rgb (i_pixel_rgb),
        .o_valid     (o_valid),
        .o_sample_rgb(o_sample_rgb),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_sampler_word     pending_words[$];
    logic [RGB_W-1:0]  sample_due_q[$];
    logic [RGB_W-1:0]  image_mem [0:DEPTH-1];
    bit                pixel_known [0:DEPTH-1];
    int                img_w = int'(RST_IMAGE_DIM);
    int                img_h = int'(RST_IMAGE_DIM);
    longint            ctr_x = 0;
    longint            ctr_y = 0;
    int                fail_count = 0;
    int                cycle_count = 0;
    int                wait_left = 0;
    int                burst_left = 0;
    t_sampler_word     cur_word;

    function automatic int eff_w();
        return (img_w > MAX_WIDTH) ? MAX_WIDTH : img_w;
    endfunction

    function automatic int eff_h();
        return (img_h > MAX_HEIGHT) ? MAX_HEIGHT : img_h;
    endfunction

    function automatic longint floor_px(longint s);
        return s >>> FRAC_BITS;
    endfunction

    function automatic longint trunc_px(longint s);
        return (s < 0) ? -((-s) >>> FRAC_BITS) : (s >>> FRAC_BITS);
    endfunction

    function automatic bit in_image(longint col, longint row);
        return col >= 0 && row >= 0 && col < eff_w() && row < eff_h();
    endfunction

    function automatic int px_addr(longint col, longint row);
        return int'(row) * MAX_WIDTH + int'(col);
    endfunction

    function automatic logic [RGB_W-1:0] pixel_at(longint col, longint row);
        if (!in_image(col, row)) begin
            return '0;
        end
        return image_mem[px_addr(col, row)];
    endfunction

    function automatic logic [RGB_W-1:0] sample_pixel(logic [OP_W-1:0] op,
                                                      logic [COORD_W-1:0] x,
                                                      logic [COORD_W-1:0] y);
        longint           sx;
        longint           sy;
        longint           x0;
        longint           y0;
        longint           fx;
        longint           fy;
        longint           acc;
        longint           w [4];
        logic [RGB_W-1:0] p [4];
        logic [RGB_W-1:0] res;
        sx = longint'($signed(x)) + ctr_x;
        sy = longint'($signed(y)) + ctr_y;
        if (op == OP_NEAREST) begin
            return pixel_at(trunc_px(sx), trunc_px(sy));
        end
        x0 = floor_px(sx);
        y0 = floor_px(sy);
        fx = sx & ((64'sd1 <<< FRAC_BITS) - 1);
        fy = sy & ((64'sd1 <<< FRAC_BITS) - 1);
        w[0] = ((64'sd1 <<< FRAC_BITS) - fx) * ((64'sd1 <<< FRAC_BITS) - fy);
        w[1] = ((64'sd1 <<< FRAC_BITS) - fx) * fy;
        w[2] = fx * ((64'sd1 <<< FRAC_BITS) - fy);
        w[3] = fx * fy;
        p[0] = pixel_at(x0, y0);
        p[1] = pixel_at(x0, y0 + 1);
        p[2] = pixel_at(x0 + 1, y0);
        p[3] = pixel_at(x0 + 1, y0 + 1);
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) begin
                acc += longint'(p[k][ch*CH_W +: CH_W]) * w[k];
            end
            acc = acc >>> (2 * FRAC_BITS);
            if (acc > 255) begin
                acc = 255;
            end
            res[ch*CH_W +: CH_W] = acc[CH_W-1:0];
        end
        return res;
    endfunction

    task automatic apply_word(t_sampler_word wd);
        longint col;
        longint row;
        if (wd.op == OP_WRITE) begin
            col = floor_px(longint'($signed(wd.x)));
            row = floor_px(longint'($signed(wd.y)));
            if (in_image(col, row)) begin
                image_mem[px_addr(col, row)] = wd.rgb;
            end
        end else if (wd.op == OP_NEAREST || wd.op == OP_BILINEAR) begin
            sample_due_q.push_back(sample_pixel(wd.op, wd.x, wd.y));
        end
    endtask

    function automatic int draw_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 9);
        return $urandom_range(15, 40);
    endfunction

    always @(posedge i_clk) begin
        logic go;
        go = start;
        if (!i_rst_n) begin
            go = 1'b0;
        end else begin
            if (start && !busy) begin
                apply_word(cur_word);
                go = 1'b0;
                wait_left = draw_gap();
            end
            if (!go) begin
                if (wait_left > 0) begin
                    wait_left--;
                end else if (pending_words.size() != 0 &&
                             !(pending_words[0].drain && sample_due_q.size() != 0)) begin
                    cur_word = pending_words.pop_front();
                    i_opcode    <= cur_word.op;
                    i_x_coord   <= cur_word.x;
                    i_y_coord   <= cur_word.y;
                    i_pixel_rgb <= cur_word.rgb;
                    go = 1'b1;
                end
            end
        end
        start <= go;
    end

    always @(posedge i_clk) begin
        logic [RGB_W-1:0] want;
        if (i_rst_n && o_valid) begin
            if (sample_due_q.size() == 0) begin
                fail_count++;
                $display("%0t: sample_rgb expected none got %06h", $time, o_sample_rgb);
            end else begin
                want = sample_due_q.pop_front();
                if (o_sample_rgb !== want) begin
                    fail_count++;
                    $display("%0t: sample_rgb expected %06h got %06h",
                             $time, want, o_sample_rgb);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic push_word(logic [OP_W-1:0] op, logic [COORD_W-1:0] x,
                             logic [COORD_W-1:0] y, logic [RGB_W-1:0] rgb);
        t_sampler_word wd;
        wd.op    = op;
        wd.x     = x;
        wd.y     = y;
        wd.rgb   = rgb;
        wd.drain = ($urandom_range(0, 59) == 0);
        pending_words.push_back(wd);
    endtask

    task automatic add_write(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [RGB_W-1:0] rgb);
        longint col;
        longint row;
        col = floor_px(longint'($signed(x)));
        row = floor_px(longint'($signed(y)));
        if (in_image(col, row)) begin
            pixel_known[px_addr(col, row)] = 1'b1;
        end
        push_word(OP_WRITE, x, y, rgb);
    endtask

    function automatic logic [RGB_W-1:0] rand_rgb();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return RGB_W'($urandom);
    endfunction

    // load any neighbour the sample reads that has not been stored yet
    task automatic cover_pixel(longint col, longint row);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        if (in_image(col, row) && !pixel_known[px_addr(col, row)]) begin
            x = COORD_W'((col <<< FRAC_BITS) + longint'($urandom_range(0, 255)));
            y = COORD_W'((row <<< FRAC_BITS) + longint'($urandom_range(0, 255)));
            add_write(x, y, rand_rgb());
        end
    endtask

    task automatic add_sample(logic [OP_W-1:0] op, logic [COORD_W-1:0] x,
                              logic [COORD_W-1:0] y);
        longint sx;
        longint sy;
        sx = longint'($signed(x)) + ctr_x;
        sy = longint'($signed(y)) + ctr_y;
        if (op == OP_NEAREST) begin
            cover_pixel(trunc_px(sx), trunc_px(sy));
        end else begin
            cover_pixel(floor_px(sx), floor_px(sy));
            cover_pixel(floor_px(sx), floor_px(sy) + 1);
            cover_pixel(floor_px(sx) + 1, floor_px(sy));
            cover_pixel(floor_px(sx) + 1, floor_px(sy) + 1);
        end
        push_word(op, x, y, RGB_W'($urandom));
    endtask

    function automatic logic [COORD_W-1:0] aim_coord(int dim, longint ctr);
        longint s;
        longint c;
        int     r;
        r = $urandom_range(0, 99);
        if (r < 4) return 24'h800000;
        if (r < 8) return 24'h7FFFFF;
        if (r < 18) begin
            c = longint'($urandom_range(0, 16777215)) + COORD_MIN;
            return c[COORD_W-1:0];
        end
        if (r < 36) s = longint'($urandom_range(0, 511)) - 256;
        else if (r < 52) s = longint'(dim) * 256 - 256 + longint'($urandom_range(0, 511));
        else if (r < 66) s = (longint'($urandom_range(0, dim + 1)) - 1) * 256;
        else s = longint'($urandom_range(0, dim * 256 + 511)) - 256;
        c = s - ctr;
        if (c < COORD_MIN || c > COORD_MAX) begin
            c = longint'($urandom_range(0, 16777215)) + COORD_MIN;
        end
        return c[COORD_W-1:0];
    endfunction

    task automatic random_mix(int n);
        int                 r;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                if (eff_w() > 0 && eff_h() > 0 && $urandom_range(0, 9) < 8) begin
                    x = COORD_W'((longint'($urandom_range(0, eff_w() - 1)) <<< FRAC_BITS)
                        + longint'($urandom_range(0, 255)));
                    y = COORD_W'((longint'($urandom_range(0, eff_h() - 1)) <<< FRAC_BITS)
                        + longint'($urandom_range(0, 255)));
                end else begin
                    x = COORD_W'($urandom);
                    y = COORD_W'($urandom);
                end
                add_write(x, y, rand_rgb());
            end else if (r < 95) begin
                add_sample((r < 65) ? OP_NEAREST : OP_BILINEAR,
                           aim_coord(eff_w(), ctr_x), aim_coord(eff_h(), ctr_y));
            end else begin
                push_word(OP_RESERVED, COORD_W'($urandom), COORD_W'($urandom),
                          RGB_W'($urandom));
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_IMAGE_WIDTH:  img_w = int'(val[DIM_W-1:0]);
            REG_IMAGE_HEIGHT: img_h = int'(val[DIM_W-1:0]);
            REG_CENTER_X:     ctr_x = longint'($signed(val));
            REG_CENTER_Y:     ctr_y = longint'($signed(val));
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(int w, int h, longint cx, longint cy, bit junk);
        logic [CFG_W-1:0] d;
        d = junk ? CFG_W'($urandom) : '0;
        d[DIM_W-1:0] = DIM_W'(w);
        write_reg(REG_IMAGE_WIDTH, d);
        d = junk ? CFG_W'($urandom) : '0;
        d[DIM_W-1:0] = DIM_W'(h);
        write_reg(REG_IMAGE_HEIGHT, d);
        write_reg(REG_CENTER_X, cx[CFG_W-1:0]);
        write_reg(REG_CENTER_Y, cy[CFG_W-1:0]);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_words.size() != 0 || start || busy || sample_due_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return $urandom_range(1, 8);
        if (r < 60) return $urandom_range(2, 32);
        if (r < 85) return $urandom_range(33, 256);
        return MAX_WIDTH;
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_write(24'h000000, 24'h000000, 24'hFFFFFF);
        add_write(24'h00FFFF, 24'h00FFFF, 24'h000000);
        add_write(24'h000100, 24'h000000, 24'h123456);
        add_write(24'h000000, 24'h000100, 24'hABCDEF);
        add_write(24'h0001FF, 24'h0001FF, 24'h00FF00);
        add_write(24'hFFFF00, 24'h000000, 24'hFFFFFF);
        add_write(24'h7FFFFF, 24'h000000, 24'hFFFFFF);
        add_write(24'h000000, 24'h800000, 24'hFFFFFF);
        add_sample(OP_NEAREST, 24'h000000, 24'h000000);
        pending_words[$].drain = 1'b1;
        add_sample(OP_NEAREST, 24'hFFFF80, 24'hFFFF80);
        add_sample(OP_NEAREST, 24'hFFFF00, 24'h000000);
        add_sample(OP_NEAREST, 24'h7FFFFF, 24'h7FFFFF);
        add_sample(OP_NEAREST, 24'h800000, 24'h800000);
        add_sample(OP_NEAREST, 24'h00FFFF, 24'h00FFFF);
        add_sample(OP_BILINEAR, 24'h000000, 24'h000000);
        add_sample(OP_BILINEAR, 24'h000080, 24'h000080);
        add_sample(OP_BILINEAR, 24'h0000FF, 24'h0000FF);
        add_sample(OP_BILINEAR, 24'hFFFF80, 24'hFFFF80);
        add_sample(OP_BILINEAR, 24'h00FF80, 24'h00FF80);
        add_sample(OP_BILINEAR, 24'h7FFFFF, 24'h800000);
        push_word(OP_RESERVED, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        random_mix(90);
        wait_idle();

        configure(1, 1, 0, 0, 1'b0);
        random_mix(28);
        wait_idle();

        configure(511, 300, COORD_MAX, 0, 1'b1);
        random_mix(28);
        wait_idle();

        configure(MAX_WIDTH, MAX_HEIGHT, COORD_MIN, COORD_MAX, 1'b0);
        random_mix(17);
        wait_idle();

        configure(0, MAX_HEIGHT, longint'($urandom_range(0, 32768)) - 16384,
                  longint'($urandom_range(0, 32768)) - 16384, 1'b0);
        random_mix(17);
        wait_idle();

        repeat (4) begin
            configure(pick_dim(), pick_dim(), longint'($urandom_range(0, 32768)) - 16384,
                      longint'($urandom_range(0, 32768)) - 16384,
                      1'($urandom_range(0, 1)));
            random_mix(34);
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
